[rtl/core/lpfd_pkg.sv]
`default_nettype none

package lpfd_pkg;

  localparam int unsigned CFG_W      = 27;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 27'd67108864;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_BAD   = 2'd2
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   frame_type;
    logic [7:0]   data_byte;
    logic         last;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/length_prefixed_frame_deframer_top.sv]
// A beat that yields a result is queued on acceptance; the out_ ports show the queue head.
// Throughput: one byte per cycle while the result queue has room; a four-entry result queue
//   decouples the parser from the consumer, and in_full is high only when the queue is full.
// Reset: rst_n is synchronous, active low; it returns the parser to length byte zero,
//   empties the queue and sets max_len_r to 2^26.
`default_nettype none

module length_prefixed_frame_deframer_top #(
  parameter int unsigned LIMIT_LOG2 = 26
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lpfd_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [7:0]                 in_byte,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [1:0]                      out_result_kind,
  output logic [7:0]                      out_frame_type,
  output logic [7:0]                      out_data_byte,
  output logic                            out_last
);
  import lpfd_pkg::*;

  logic    beat_en;
  logic    res_valid;
  result_t res;
  result_t head;

  assign beat_en = in_push && !in_full;

  lpfd_parser #(
    .LIMIT_LOG2(LIMIT_LOG2)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .beat_en    (beat_en),
    .beat_byte  (in_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  lpfd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .full     (in_full),
    .pop      (out_pop),
    .empty    (out_empty),
    .head_data(head)
  );

  assign out_result_kind = head.kind;
  assign out_frame_type  = head.frame_type;
  assign out_data_byte   = head.data_byte;
  assign out_last        = head.last;

endmodule

`default_nettype wire

[rtl/core/lpfd_parser.sv]
`default_nettype none

module lpfd_parser #(
  parameter int unsigned LIMIT_LOG2 = 26
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lpfd_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                       beat_en,
  input  wire logic [7:0]                 beat_byte,
  output logic                            res_valid,
  output lpfd_pkg::result_t               res
);
  import lpfd_pkg::*;

  localparam int unsigned LIM_W = 33;

  typedef enum logic [2:0] {
    PH_LEN0 = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_LEN3 = 3'd3,
    PH_TYPE = 3'd4,
    PH_DATA = 3'd5
  } phase_t;

  localparam logic [LIM_W-1:0] HARD_LIM = LIM_W'(1) << LIMIT_LOG2;

  phase_t           phase_r, phase_nxt;
  logic [23:0]      len_acc_r, len_acc_nxt;
  logic [CFG_W-1:0] left_r, left_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [CFG_W-1:0] max_len_r;

  logic [31:0]      len_full;
  logic [LIM_W-1:0] cfg_lim;
  logic [LIM_W-1:0] lim;
  logic             bad_len;

  assign len_full = {beat_byte, len_acc_r};
  assign cfg_lim  = LIM_W'(max_len_r);
  assign lim      = (HARD_LIM < cfg_lim) ? HARD_LIM : cfg_lim;
  assign bad_len  = (len_full == 32'd0) || (LIM_W'(len_full) > lim);

  always_comb begin
    phase_nxt   = phase_r;
    len_acc_nxt = len_acc_r;
    left_nxt    = left_r;
    type_nxt    = type_r;
    res_valid   = 1'b0;
    res         = '{kind: KIND_DATA, frame_type: 8'd0, data_byte: 8'd0, last: 1'b0};
    if (beat_en) begin
      unique case (phase_r)
        PH_LEN1: begin
          len_acc_nxt[15:8] = beat_byte;
          phase_nxt         = PH_LEN2;
        end
        PH_LEN2: begin
          len_acc_nxt[23:16] = beat_byte;
          phase_nxt          = PH_LEN3;
        end
        PH_LEN3: begin
          len_acc_nxt = 24'd0;
          if (bad_len) begin
            phase_nxt = PH_LEN0;
            res_valid = 1'b1;
            res.kind  = KIND_BAD;
            res.last  = 1'b1;
          end else begin
            left_nxt  = CFG_W'(len_full - 32'd1);
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt = beat_byte;
          if (left_r == '0) begin
            phase_nxt      = PH_LEN0;
            res_valid      = 1'b1;
            res.kind       = KIND_EMPTY;
            res.frame_type = beat_byte;
            res.last       = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid      = 1'b1;
          res.frame_type = type_r;
          res.data_byte  = beat_byte;
          res.last       = (left_r <= CFG_W'(1));
          if (left_r != '0) begin
            left_nxt = left_r - CFG_W'(1);
          end
          phase_nxt = res.last ? PH_LEN0 : PH_DATA;
        end
        default: begin
          len_acc_nxt = {16'd0, beat_byte};
          phase_nxt   = PH_LEN1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN0;
      len_acc_r <= 24'd0;
      left_r    <= '0;
      type_r    <= 8'd0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      phase_r   <= phase_nxt;
      len_acc_r <= len_acc_nxt;
      left_r    <= left_nxt;
      type_r    <= type_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/lpfd_fifo.sv]
`default_nettype none

module lpfd_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  lpfd_pkg::result_t push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output lpfd_pkg::result_t head_data
);
  import lpfd_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  result_t          slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[bench/lpfd_checker.sv]
`default_nettype none

module lpfd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lpfd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic [7:0]                 in_byte,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic [1:0]                 out_result_kind,
  input  logic [7:0]                 out_frame_type,
  input  logic [7:0]                 out_data_byte,
  input  logic                       out_last,
  output int unsigned                mismatches,
  output int unsigned                outstanding
);
  import lpfd_pkg::*;

  localparam logic [31:0] LEN_HARD_CAP = 32'd1 << 26;

  typedef enum logic [2:0] {
    PH_LEN0 = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_LEN3 = 3'd3,
    PH_TYPE = 3'd4,
    PH_DATA = 3'd5
  } parse_phase_t;

  parse_phase_t     phase;
  logic [31:0]      len_acc;
  logic [26:0]      bytes_left;
  logic [7:0]       held_type;
  logic [CFG_W-1:0] max_len;
  result_t          pending_results[$];

  task automatic deframe_byte(input logic [7:0] b);
    logic [31:0] cap;
    logic        is_last;
    case (phase)
      PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
        if (phase == PH_LEN0) len_acc = 32'd0;
        len_acc[8*int'(phase) +: 8] = b;
        if (phase != PH_LEN3) begin
          phase = parse_phase_t'(phase + 3'd1);
        end else begin
          cap = {{(32-CFG_W){1'b0}}, max_len};
          if (cap > LEN_HARD_CAP) cap = LEN_HARD_CAP;
          if (len_acc == 32'd0 || len_acc > cap) begin
            pending_results.push_back('{kind: KIND_BAD, frame_type: 8'h00,
                                        data_byte: 8'h00, last: 1'b1});
            len_acc = 32'd0;
            phase = PH_LEN0;
          end else begin
            bytes_left = 27'(len_acc - 32'd1);
            phase = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        held_type = b;
        if (bytes_left == 27'd0) begin
          pending_results.push_back('{kind: KIND_EMPTY, frame_type: b,
                                      data_byte: 8'h00, last: 1'b1});
          phase = PH_LEN0;
        end else begin
          phase = PH_DATA;
        end
      end
      default: begin
        is_last = (bytes_left <= 27'd1);
        if (bytes_left != 27'd0) bytes_left = bytes_left - 27'd1;
        pending_results.push_back('{kind: KIND_DATA, frame_type: held_type,
                                    data_byte: b, last: is_last});
        phase = is_last ? PH_LEN0 : PH_DATA;
      end
    endcase
  endtask

  task automatic check_beat();
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: kind=%0d type=%02h data=%02h last=%0b",
                 out_result_kind, out_frame_type, out_data_byte, out_last);
      return;
    end
    want = pending_results.pop_front();
    if (out_result_kind !== want.kind || out_frame_type !== want.frame_type ||
        out_data_byte !== want.data_byte || out_last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp k=%0d t=%02h d=%02h l=%0b got k=%0d t=%02h d=%02h l=%0b",
                 want.kind, want.frame_type, want.data_byte, want.last,
                 out_result_kind, out_frame_type, out_data_byte, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = PH_LEN0;
      len_acc    = 32'd0;
      bytes_left = 27'd0;
      held_type  = 8'h00;
      max_len    = MAX_LEN_RESET;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (out_pop && !out_empty) check_beat();
      if (in_push && !in_full) deframe_byte(in_byte);
      if (cfg_wr_en) max_len = cfg_wr_data;
    end
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;
  import lpfd_pkg::*;

  localparam logic [31:0] LEN_HARD_CAP = 32'd1 << 26;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_push     = 1'b0;
  logic [7:0]       in_byte     = 8'h00;
  logic             out_pop     = 1'b0;
  logic             in_full;
  logic             out_empty;
  logic [1:0]       out_result_kind;
  logic [7:0]       out_frame_type;
  logic [7:0]       out_data_byte;
  logic             out_last;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned beats     = 0;
  logic [31:0] len_cap   = LEN_HARD_CAP;
  bit          noise_on  = 1'b0;

  length_prefixed_frame_deframer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_byte         (in_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_kind (out_result_kind),
    .out_frame_type  (out_frame_type),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last)
  );

  lpfd_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_byte         (in_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_kind (out_result_kind),
    .out_frame_type  (out_frame_type),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats++;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  // drop the body when the header is rejected, so the stream stays aligned
  task automatic send_frame(input logic [31:0] len, input logic [7:0] ftype);
    send_header(len);
    if (len == 32'd0 || len > len_cap) return;
    send_byte(ftype);
    for (int unsigned i = 1; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_cap = ({5'd0, v} > LEN_HARD_CAP) ? LEN_HARD_CAP : {5'd0, v};
  endtask

  function automatic logic [31:0] good_len();
    logic [31:0] span;
    span = (len_cap < 32'd16) ? len_cap : 32'd16;
    if (len_cap == 32'd0) return 32'd1;
    if ($urandom_range(99) < 8) return (len_cap < 32'd64) ? len_cap : 32'd64;
    return $urandom_range(span, 1);
  endfunction

  function automatic logic [31:0] bad_len();
    case ($urandom_range(2))
      0:       return 32'd0;
      1:       return len_cap + 32'd1;
      default: return $urandom | 32'h0400_0001;
    endcase
  endfunction

  task automatic run_random(input int unsigned target);
    int unsigned pick;
    while (beats < target) begin
      pick = $urandom_range(99);
      if (noise_on && pick < 6) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      end else if (pick < 18) begin
        send_frame(bad_len(), 8'($urandom_range(255)));
      end else begin
        send_frame(good_len(), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 22;
    recv_idle = 80;
    send_frame(32'd1, 8'h00);
    send_header(32'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(32'd0, 8'h00);
    send_frame(32'hFFFF_FFFF, 8'h00);
    send_frame(LEN_HARD_CAP + 32'd1, 8'h00);
    run_random(600);

    write_max_len('0);
    send_frame(32'd1, 8'h11);
    send_frame(32'd2, 8'h22);
    write_max_len(27'd1);
    send_frame(32'd1, 8'h33);
    send_frame(32'd2, 8'h44);

    write_max_len({CFG_W{1'b1}});
    send_idle = 80;
    recv_idle = 22;
    run_random(1180);

    // misaligned noise is safe only under a small length cap
    write_max_len(27'd40);
    send_idle = 0;
    recv_idle = 0;
    noise_on  = 1'b1;
    run_random(1750);

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_parser.sv
rtl/core/lpfd_fifo.sv
rtl/core/length_prefixed_frame_deframer_top.sv
bench/lpfd_checker.sv
bench/tb_top.sv
